@@ rtl/mpeg2_inverse_quantizer_core_assert.svh @@
// assertion macros used by the inverse quantizer back end
// each use expects clk and arst_n in scope
`ifndef MPEG2_INVERSE_QUANTIZER_CORE_ASSERT_SVH
`define MPEG2_INVERSE_QUANTIZER_CORE_ASSERT_SVH

// same-cycle implication
`define IQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("inverse quantizer check failed");

// next-cycle implication
`define IQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("inverse quantizer check failed");

`endif

@@ rtl/mpeg2_iq_pkg.sv @@
// shared types, widths and the quantiser scale table for the inverse quantizer
// no dependencies
`default_nettype none

package mpeg2_iq_pkg;

	localparam int COEFF_W   = 12;
	localparam int WEIGHT_W  = 8;
	localparam int POS_W     = 6;
	localparam int CODE_W    = 5;
	localparam int DCP_W     = 2;
	localparam int SCALE_W   = 7;
	localparam int OPERAND_W = 15;
	localparam int PROD1_W   = 23;
	localparam int PROD2_W   = 30;
	localparam int DIV_SHIFT = 5;
	localparam int QUOT_W    = PROD2_W - DIV_SHIFT;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [POS_W-1:0] FIRST_POS = 6'd0;
	localparam logic [POS_W-1:0] LAST_POS  = 6'd63;

	localparam logic [SCALE_W-1:0]  DC_SCALE  = 7'd32;
	localparam logic [WEIGHT_W-1:0] DC_WEIGHT = 8'd1;

	localparam logic signed [PROD2_W-1:0] DIV_BIAS = 30'sd31;
	localparam logic signed [QUOT_W-1:0]  QUOT_MAX = 25'sd2047;
	localparam logic signed [QUOT_W-1:0]  QUOT_MIN = -25'sd2048;
	localparam logic signed [COEFF_W-1:0] COEFF_MAX = 12'sd2047;
	localparam logic signed [COEFF_W-1:0] COEFF_MIN = -12'sd2048;

	typedef enum logic {
		REG_DC_PRECISION     = 1'b0,
		REG_SCALE_TABLE_KIND = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_DC       = 2'd0,
		KIND_INTRA_AC = 2'd1,
		KIND_INTER    = 2'd2
	} coeff_kind_t;

	typedef struct packed {
		logic signed [OPERAND_W-1:0] operand;
		logic [WEIGHT_W-1:0]         weight;
		logic [SCALE_W-1:0]          scale;
		logic [POS_W-1:0]            position;
	} queue_word_t;

	function automatic logic [SCALE_W-1:0] nonlinear_scale(input logic [CODE_W-1:0] code);
		logic [SCALE_W-1:0] s;
		case (code)
			5'd0:    s = 7'd0;
			5'd1:    s = 7'd1;
			5'd2:    s = 7'd2;
			5'd3:    s = 7'd3;
			5'd4:    s = 7'd4;
			5'd5:    s = 7'd5;
			5'd6:    s = 7'd6;
			5'd7:    s = 7'd7;
			5'd8:    s = 7'd8;
			5'd9:    s = 7'd10;
			5'd10:   s = 7'd12;
			5'd11:   s = 7'd14;
			5'd12:   s = 7'd16;
			5'd13:   s = 7'd18;
			5'd14:   s = 7'd20;
			5'd15:   s = 7'd22;
			5'd16:   s = 7'd24;
			5'd17:   s = 7'd28;
			5'd18:   s = 7'd32;
			5'd19:   s = 7'd36;
			5'd20:   s = 7'd40;
			5'd21:   s = 7'd44;
			5'd22:   s = 7'd48;
			5'd23:   s = 7'd52;
			5'd24:   s = 7'd56;
			5'd25:   s = 7'd64;
			5'd26:   s = 7'd72;
			5'd27:   s = 7'd80;
			5'd28:   s = 7'd88;
			5'd29:   s = 7'd96;
			5'd30:   s = 7'd104;
			5'd31:   s = 7'd112;
			default: s = 7'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ rtl/mpeg2_iq_front.sv @@
// front end: configuration registers, input acceptance and coefficient classification
// depends on mpeg2_iq_pkg
`default_nettype none

module mpeg2_iq_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic                                   cfg_index,
	input  wire logic [mpeg2_iq_pkg::DCP_W-1:0]         cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [mpeg2_iq_pkg::COEFF_W-1:0] coeff_in,
	input  wire logic [mpeg2_iq_pkg::WEIGHT_W-1:0]      weight,
	input  wire logic [mpeg2_iq_pkg::POS_W-1:0]         position,
	input  wire logic                                   is_intra,
	input  wire logic [mpeg2_iq_pkg::CODE_W-1:0]        scale_code,
	input  wire logic                                   q_full,
	output logic                                        q_push,
	output mpeg2_iq_pkg::queue_word_t                   q_word
);
	import mpeg2_iq_pkg::*;

	logic [DCP_W-1:0]           dc_precision_q;
	logic                       scale_table_kind_q;
	coeff_kind_t                kind;
	logic [SCALE_W-1:0]         table_scale;
	logic signed [OPERAND_W-1:0] coeff_ext;
	logic signed [OPERAND_W-1:0] sign_ext;
	logic [DCP_W-1:0]           dc_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_precision_q     <= '0;
			scale_table_kind_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_DC_PRECISION:     dc_precision_q     <= cfg_data;
				REG_SCALE_TABLE_KIND: scale_table_kind_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (is_intra && position == FIRST_POS) begin
			kind = KIND_DC;
		end else if (is_intra) begin
			kind = KIND_INTRA_AC;
		end else begin
			kind = KIND_INTER;
		end
	end

	assign table_scale = scale_table_kind_q ? nonlinear_scale(scale_code)
	                                        : {1'b0, scale_code, 1'b0};
	assign coeff_ext   = OPERAND_W'(coeff_in);
	assign sign_ext    = coeff_in[COEFF_W-1] ? -15'sd1 :
	                     ((coeff_in != '0) ? 15'sd1 : 15'sd0);
	assign dc_shift    = 2'd3 - dc_precision_q;

	always_comb begin
		q_word.position = position;
		case (kind)
			KIND_DC: begin
				q_word.operand = coeff_ext <<< dc_shift;
				q_word.weight  = DC_WEIGHT;
				q_word.scale   = DC_SCALE;
			end
			KIND_INTRA_AC: begin
				q_word.operand = coeff_ext <<< 1;
				q_word.weight  = weight;
				q_word.scale   = table_scale;
			end
			KIND_INTER: begin
				q_word.operand = (coeff_ext <<< 1) + sign_ext;
				q_word.weight  = weight;
				q_word.scale   = table_scale;
			end
			default: begin
				q_word.operand = '0;
				q_word.weight  = '0;
				q_word.scale   = '0;
			end
		endcase
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

@@ rtl/mpeg2_iq_queue.sv @@
// short queue between the classifying front end and the arithmetic back end
// depends on mpeg2_iq_pkg
`default_nettype none

module mpeg2_iq_queue (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  mpeg2_iq_pkg::queue_word_t      push_word,
	output logic                           full,
	input  wire logic                      pop,
	output logic                           not_empty,
	output mpeg2_iq_pkg::queue_word_t      pop_word
);
	import mpeg2_iq_pkg::*;

	queue_word_t       slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = count_q == QCNT_W'(QDEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_word  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/mpeg2_iq_back.sv @@
// back end: two multiplier stages, truncating divide by 32, saturation,
// block parity and mismatch control, output register; depends on mpeg2_iq_pkg
`default_nettype none

`include "mpeg2_inverse_quantizer_core_assert.svh"

module mpeg2_iq_back (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    q_not_empty,
	input  mpeg2_iq_pkg::queue_word_t                    q_word,
	output logic                                         q_pop,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic signed [mpeg2_iq_pkg::COEFF_W-1:0]      coeff_out,
	output logic [mpeg2_iq_pkg::POS_W-1:0]               out_position,
	output logic                                         block_last
);
	import mpeg2_iq_pkg::*;

	logic                        advance;
	logic                        valid_s1;
	logic signed [PROD1_W-1:0]   prod_s1;
	logic [SCALE_W-1:0]          scale_s1;
	logic [POS_W-1:0]            pos_s1;
	logic                        valid_s2;
	logic signed [PROD2_W-1:0]   prod_s2;
	logic [POS_W-1:0]            pos_s2;
	logic                        out_valid_q;
	logic signed [COEFF_W-1:0]   coeff_q;
	logic [POS_W-1:0]            pos_q;
	logic                        last_q;
	logic                        parity_q;

	logic signed [PROD2_W-1:0]   biased;
	logic signed [QUOT_W-1:0]    quot;
	logic signed [COEFF_W-1:0]   sat;
	logic                        parity_base;
	logic                        parity_new;
	logic                        is_last;
	logic                        flip;

	assign advance = !out_valid_q || out_ready;
	assign q_pop   = advance && q_not_empty;

	// stage 1: operand times weight
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1  <= PROD1_W'(q_word.operand * $signed({1'b0, q_word.weight}));
			scale_s1 <= q_word.scale;
			pos_s1   <= q_word.position;
		end
	end

	// stage 2: times quantiser scale
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2 <= PROD2_W'(prod_s1 * $signed({1'b0, scale_s1}));
			pos_s2  <= pos_s1;
		end
	end

	// divide by 32 toward zero, then saturate
	assign biased = prod_s2 + (prod_s2[PROD2_W-1] ? DIV_BIAS : '0);
	assign quot   = QUOT_W'(biased >>> DIV_SHIFT);

	always_comb begin
		if (quot > QUOT_MAX) begin
			sat = COEFF_MAX;
		end else if (quot < QUOT_MIN) begin
			sat = COEFF_MIN;
		end else begin
			sat = COEFF_W'(quot);
		end
	end

	assign is_last     = pos_s2 == LAST_POS;
	assign parity_base = (pos_s2 == FIRST_POS) ? 1'b0 : parity_q;
	assign parity_new  = parity_base ^ sat[0];
	assign flip        = is_last && !parity_new;

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			coeff_q <= {sat[COEFF_W-1:1], sat[0] ^ flip};
			pos_q   <= pos_s2;
			last_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			parity_q    <= 1'b0;
		end else if (advance) begin
			valid_s1    <= q_not_empty;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
			if (valid_s2) begin
				parity_q <= parity_new;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign coeff_out    = coeff_q;
	assign out_position = pos_q;
	assign block_last   = last_q;

	`IQ_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(prod_s1))
	`IQ_ASSERT_NEXT(a_s2_holds, valid_s2 && !advance,
		valid_s2 && $stable(prod_s2) && $stable(pos_s2))
	`IQ_ASSERT_NOW(a_out_from_s2, $rose(out_valid_q), $past(valid_s2))

endmodule

`default_nettype wire

@@ rtl/mpeg2_inverse_quantizer_core.sv @@
// MPEG-2 inverse quantizer with saturation and mismatch control. Coefficients of an
// 8x8 block enter in raster order with their weight, scale code and intra flag and
// leave dequantized, saturated to -2048..2047, with the LSB of position 63 toggled
// when the block sum is even. One word is taken and one delivered per cycle when
// neither side stalls; an accepted word is written into the queue at the accepting
// edge, then passes the two registered multiplier stages and the output register.
// A four-word queue separates input acceptance from the arithmetic, so the input
// keeps being taken for up to four words while the output is stalled.
// Configuration registers: index 0 dc_precision, index 1 scale_table_kind; write
// them only while no word is in flight. Depends on mpeg2_iq_pkg and the front,
// queue and back modules.
`default_nettype none

module mpeg2_inverse_quantizer_core (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_write,
	input  wire logic                                     cfg_index,
	input  wire logic [mpeg2_iq_pkg::DCP_W-1:0]           cfg_data,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic signed [mpeg2_iq_pkg::COEFF_W-1:0]  coeff_in,
	input  wire logic [mpeg2_iq_pkg::WEIGHT_W-1:0]        weight,
	input  wire logic [mpeg2_iq_pkg::POS_W-1:0]           position,
	input  wire logic                                     is_intra,
	input  wire logic [mpeg2_iq_pkg::CODE_W-1:0]          scale_code,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic signed [mpeg2_iq_pkg::COEFF_W-1:0]       coeff_out,
	output logic [mpeg2_iq_pkg::POS_W-1:0]                out_position,
	output logic                                          block_last
);
	import mpeg2_iq_pkg::*;

	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_not_empty;
	queue_word_t push_word;
	queue_word_t pop_word;

	mpeg2_iq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.coeff_in   (coeff_in),
		.weight     (weight),
		.position   (position),
		.is_intra   (is_intra),
		.scale_code (scale_code),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_word     (push_word)
	);

	mpeg2_iq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_word  (pop_word)
	);

	mpeg2_iq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_word       (pop_word),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.coeff_out    (coeff_out),
		.out_position (out_position),
		.block_last   (block_last)
	);

endmodule

`default_nettype wire
